[rtl/subnet_coincidence_trigger_voter_assert.svh]
// Assertion macros for the subnet coincidence voter.
// Every macro samples on clk and is off while rst_n is low.
`ifndef SUBNET_COINCIDENCE_TRIGGER_VOTER_ASSERT_SVH
`define SUBNET_COINCIDENCE_TRIGGER_VOTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCTV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCTV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sctv_pkg.sv]
`timescale 1ns / 1ps

package sctv_pkg;

    // Default sizing
    localparam int DEF_NUM_STATIONS = 64;
    localparam int DEF_NUM_SUBNETS  = 32;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int SIDX_W     = 5;
    localparam int MASK_W     = 64;
    localparam int VOTE_W     = 7;
    localparam int DUR_W      = 22;
    localparam int ACT_W      = 6;
    localparam int FLAG_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SUB_CFG_W  = 6;
    localparam int TIME_W     = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EVAL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNETS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_TRIG_DUR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_CONTRIB = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SIDX_W-1:0] subnet_index;
        logic [MASK_W-1:0] member_mask;
        logic [VOTE_W-1:0] min_votes;
        logic [MASK_W-1:0] station_triggered;
    } request_t;

    typedef struct packed {
        logic [DUR_W-1:0]  duration;
        logic              net_active;
        logic [ACT_W-1:0]  active_count;
        logic [ACT_W-1:0]  max_active;
        logic [FLAG_W-1:0] fired_flags;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_EMIT
    } sctv_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic issue;
        logic calc;
        logic load_out;
    } sctv_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_eval;
        logic scan_done;
        logic pipe_busy;
        logic out_free;
    } sctv_status_t;

endpackage

[rtl/sctv_ctrl.sv]
`timescale 1ns / 1ps

module sctv_ctrl
    import sctv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         request_valid,
    output logic         request_stall,
    input  sctv_status_t status,
    output sctv_cmd_t    cmd
);

    sctv_state_t state_reg;
    sctv_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request_valid)
                begin
                    state_next = status.req_eval ? ST_SCAN : ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                // leave once every entry is issued and the count pipe is empty
                if (status.scan_done && !status.pipe_busy)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        request_stall = (state_reg != ST_IDLE);
        cmd.accept    = (state_reg == ST_IDLE) && request_valid;
        cmd.issue     = (state_reg == ST_SCAN) && !status.scan_done;
        cmd.calc      = (state_reg == ST_CALC);
        cmd.load_out  = (state_reg == ST_EMIT) && status.out_free;
    end

endmodule

[rtl/sctv_datapath.sv]
`timescale 1ns / 1ps

module sctv_datapath
    import sctv_pkg::*;
#(
    parameter int NUM_STATIONS = DEF_NUM_STATIONS,
    parameter int NUM_SUBNETS  = DEF_NUM_SUBNETS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  request_t              request,
    output result_t               result,
    output logic                  result_valid,
    input  logic                  result_stall,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  sctv_cmd_t             cmd,
    output sctv_status_t          status
);

    localparam int IDX_W     = (NUM_SUBNETS > 1) ? $clog2(NUM_SUBNETS) : 1;
    localparam int CNT_W     = $clog2(NUM_SUBNETS + 1);
    localparam int NUM_BYTES = (NUM_STATIONS + 7) / 8;
    localparam int PAD_W     = NUM_BYTES * 8;
    localparam logic [SUB_CFG_W-1:0] SUBNETS_MAX = SUB_CFG_W'(NUM_SUBNETS);

    function automatic logic [3:0] count_byte(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    // Configuration registers
    logic [SUB_CFG_W-1:0] subnets_reg;
    logic [TIME_W-1:0]    net_dur_reg;
    logic [TIME_W-1:0]    contrib_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subnets_reg <= '0;
            net_dur_reg <= '0;
            contrib_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SUBNETS_IN_USE: subnets_reg <= cfg_data[SUB_CFG_W-1:0];
                CFG_NET_TRIG_DUR:   net_dur_reg <= cfg_data;
                CFG_SUBNET_CONTRIB: contrib_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Saturate entry count to the table depth
    logic [CNT_W-1:0] limit;
    assign limit = (subnets_reg > SUBNETS_MAX) ? CNT_W'(NUM_SUBNETS)
                                               : subnets_reg[CNT_W-1:0];

    logic is_load;
    logic is_clear;
    logic mem_we;
    assign is_load  = (request.req_type == REQ_LOAD);
    assign is_clear = (request.req_type == REQ_CLEAR);
    assign mem_we   = cmd.accept && is_load
                      && ({1'b0, request.subnet_index} < SUBNETS_MAX);

    // Scan address counter
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [IDX_W-1:0] rd_addr;
    assign rd_addr = scan_cnt_reg[IDX_W-1:0];

    // Subnet table
    logic [NUM_STATIONS-1:0] mask_mem [NUM_SUBNETS];
    logic [VOTE_W-1:0]       vote_mem [NUM_SUBNETS];
    logic [NUM_STATIONS-1:0] rd_mask_reg;
    logic [VOTE_W-1:0]       rd_vote_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mask_mem[request.subnet_index[IDX_W-1:0]] <= request.member_mask[NUM_STATIONS-1:0];
            vote_mem[request.subnet_index[IDX_W-1:0]] <= request.min_votes;
        end
        if (cmd.issue)
        begin
            rd_mask_reg <= mask_mem[rd_addr];
            rd_vote_reg <= vote_mem[rd_addr];
        end
    end

    // Count pipeline: table read, byte counts, sum and compare
    logic                    p1_valid_reg;
    logic                    p2_valid_reg;
    logic [IDX_W-1:0]        p1_idx_reg;
    logic [IDX_W-1:0]        p2_idx_reg;
    logic [VOTE_W-1:0]       p2_vote_reg;
    logic [3:0]              bc_reg [NUM_BYTES];
    logic [NUM_STATIONS-1:0] trig_reg;
    logic [PAD_W-1:0]        masked_pad;
    logic [VOTE_W-1:0]       vote_sum;
    logic                    fire;

    assign masked_pad = PAD_W'(rd_mask_reg & trig_reg);

    always_comb
    begin
        vote_sum = '0;
        for (int b = 0; b < NUM_BYTES; b++)
        begin
            vote_sum = vote_sum + VOTE_W'(bc_reg[b]);
        end
    end

    assign fire = p2_valid_reg && (vote_sum >= p2_vote_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            p1_valid_reg <= cmd.issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            trig_reg <= request.station_triggered[NUM_STATIONS-1:0];
        end
        p1_idx_reg  <= rd_addr;
        p2_idx_reg  <= p1_idx_reg;
        p2_vote_reg <= rd_vote_reg;
        for (int b = 0; b < NUM_BYTES; b++)
        begin
            bc_reg[b] <= count_byte(masked_pad[b*8 +: 8]);
        end
    end

    // Vote state
    logic [NUM_SUBNETS-1:0] sticky_reg;
    logic [ACT_W-1:0]       active_cnt_reg;
    logic [ACT_W-1:0]       max_reg;
    logic [DUR_W-1:0]       duration_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_reg     <= '0;
            active_cnt_reg <= '0;
            max_reg        <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                active_cnt_reg <= '0;
                if (is_clear)
                begin
                    sticky_reg <= '0;
                    max_reg    <= '0;
                end
            end
            else if (fire)
            begin
                sticky_reg[p2_idx_reg] <= 1'b1;
                active_cnt_reg         <= active_cnt_reg + 1'b1;
            end
            if (cmd.calc && (active_cnt_reg > max_reg))
            begin
                max_reg <= active_cnt_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            duration_reg <= '0;
        end
        else if (cmd.calc && (active_cnt_reg != '0))
        begin
            duration_reg <= DUR_W'(net_dur_reg)
                            + DUR_W'(DUR_W'(active_cnt_reg) * DUR_W'(contrib_reg));
        end
    end

    // Output register
    logic    result_valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.duration     <= duration_reg;
            result_reg.net_active   <= (active_cnt_reg != '0);
            result_reg.active_count <= active_cnt_reg;
            result_reg.max_active   <= max_reg;
            result_reg.fired_flags  <= FLAG_W'(sticky_reg);
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign status.req_eval  = (request.req_type == REQ_EVAL);
    assign status.scan_done = (scan_cnt_reg == limit);
    assign status.pipe_busy = p1_valid_reg || p2_valid_reg;
    assign status.out_free  = !result_valid_reg || !result_stall;

endmodule

[rtl/subnet_coincidence_trigger_voter.sv]
`timescale 1ns / 1ps
// Subnet coincidence voter for a seismic trigger network.
// Request channel (request_valid / request_stall / request) carries one item:
// load a subnet entry, evaluate a station trigger vector, or clear the
// sticky fired flags and the running maximum. Every item yields exactly one
// result item on the result channel (result_valid / result_stall / result).
// Configuration (cfg_we / cfg_index / cfg_data) sets the number of subnets
// evaluated and the duration terms; write it only while the block is idle.
// A load, clear or unused request goes straight to its result load. An
// evaluate scans the saturated number of subnets in use: the scan reads
// one table entry per cycle through the subnet table, followed by a
// two-stage popcount pipe, the duration multiply and the result load.
// The block takes one item at a time; request_stall is low only while idle.
// A finished result sits in the output register, so the next item is
// accepted while the result still waits; that item is held before its own
// result load until the receiver takes the old one.
// Reset clears the configuration, the fired flags, the maximum and the
// control state. The subnet table is not cleared: load an entry before
// evaluating it.
`include "subnet_coincidence_trigger_voter_assert.svh"

module subnet_coincidence_trigger_voter
    import sctv_pkg::*;
#(
    parameter int NUM_STATIONS = DEF_NUM_STATIONS,
    parameter int NUM_SUBNETS  = DEF_NUM_SUBNETS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  request_valid,
    output logic                  request_stall,
    input  request_t              request,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sctv_cmd_t    cmd;
    sctv_status_t status;

    // Sequencing: accept, scan the table, compute duration, load the result
    sctv_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .status        (status),
        .cmd           (cmd)
    );

    // Table, vote pipeline, fired flags, configuration and result register
    sctv_datapath #(
        .NUM_STATIONS (NUM_STATIONS),
        .NUM_SUBNETS  (NUM_SUBNETS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status)
    );

    // An accepted item always keeps the block busy in the cycle after its acceptance
    `SCTV_ASSERT_NEXT(a_busy_after_accept, request_valid && !request_stall, request_stall, "block took a second item back to back")
    // Never load a result while vote counts are still in flight
    `SCTV_ASSERT_SAME(a_load_after_drain, cmd.load_out, !status.pipe_busy, "result loaded with votes in flight")
    // Network activity flag agrees with the active count
    `SCTV_ASSERT_SAME(a_active_flag, result_valid, result.net_active == (result.active_count != '0), "net_active disagrees with active_count")
    // Running maximum bounds this evaluation, and an idle network has no duration
    `SCTV_ASSERT_SAME(a_max_and_duration, result_valid, (result.active_count <= result.max_active) && (result.net_active || (result.duration == '0)), "maximum or duration inconsistent")

endmodule
